>>> rtl/core/swpd_pkg.sv
// shared constants and types for the sync word packet deframer
`default_nettype none

package swpd_pkg;

   // sync pair that opens every packet
   localparam logic [7:0] SyncFirst  = 8'hCC;
   localparam logic [7:0] SyncSecond = 8'h44;

   // command table size and widths
   localparam int TableEntries    = 6;
   localparam int EntryIndexWidth = 3;
   localparam int CsrIndexWidth   = 3;
   localparam int CsrDataWidth    = 16;

   // csr register indexes
   localparam logic [CsrIndexWidth-1:0] CsrEntryCount = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEntryZero  = 3'd1;

   // one result transaction
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        packet_end;
      logic [7:0]  module_id;
      logic [7:0]  command_id;
      logic [7:0]  status_byte;
      logic [15:0] payload_length;
      logic [15:0] check_word;
      logic        matched;
      logic [EntryIndexWidth-1:0] entry_index;
   } swpd_result_type;

   // command table lookup outcome
   typedef struct packed {
      logic                       hit;
      logic [EntryIndexWidth-1:0] index;
   } swpd_match_type;

endpackage

`default_nettype wire

>>> rtl/core/swpd_if.sv
// valid/ready channel interfaces for received bytes and deframed results
`default_nettype none

interface swpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic        packet_end;
   logic [7:0]  module_id;
   logic [7:0]  command_id;
   logic [7:0]  status_byte;
   logic [15:0] payload_length;
   logic [15:0] check_word;
   logic        matched;
   logic [2:0]  entry_index;

   modport source (
      output valid, output payload_valid, output payload_byte, output packet_end,
      output module_id, output command_id, output status_byte,
      output payload_length, output check_word, output matched, output entry_index,
      input ready
   );
   modport sink (
      input valid, input payload_valid, input payload_byte, input packet_end,
      input module_id, input command_id, input status_byte,
      input payload_length, input check_word, input matched, input entry_index,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/swpd_parser.sv
// byte-level header parser: sync hunt, header capture, payload countdown
`default_nettype none

module swpd_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               rx_byte,
   output logic                          res_valid,
   output swpd_pkg::swpd_result_type     res,
   output logic [7:0]                    held_module,
   output logic [7:0]                    held_command
);
   import swpd_pkg::*;

   typedef enum logic [3:0] {
      PhHunt     = 4'd0,
      PhGotFirst = 4'd1,
      PhModule   = 4'd2,
      PhCommand  = 4'd3,
      PhStatus   = 4'd4,
      PhLenHi    = 4'd5,
      PhLenLo    = 4'd6,
      PhChkHi    = 4'd7,
      PhChkLo    = 4'd8,
      PhData     = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  module_ff, module_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  status_ff, status_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] check_ff, check_in;
   logic [15:0] left_ff, left_in;
   logic        pv;
   logic        pend;

   // next state for one accepted byte
   always_comb begin
      phase_in   = phase_ff;
      module_in  = module_ff;
      command_in = command_ff;
      status_in  = status_ff;
      length_in  = length_ff;
      check_in   = check_ff;
      left_in    = left_ff;
      res_valid  = 1'b0;
      pv         = 1'b0;
      pend       = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PhGotFirst: begin
               if (rx_byte == SyncSecond) begin
                  phase_in = PhModule;
               end else if (rx_byte == SyncFirst) begin
                  phase_in = PhGotFirst;
               end else begin
                  phase_in = PhHunt;
               end
            end
            PhModule: begin
               module_in = rx_byte;
               phase_in  = PhCommand;
            end
            PhCommand: begin
               command_in = rx_byte;
               phase_in   = PhStatus;
            end
            PhStatus: begin
               status_in = rx_byte;
               phase_in  = PhLenHi;
            end
            PhLenHi: begin
               length_in = {rx_byte, 8'h00};
               phase_in  = PhLenLo;
            end
            PhLenLo: begin
               length_in = {length_ff[15:8], rx_byte};
               phase_in  = PhChkHi;
            end
            PhChkHi: begin
               check_in = {rx_byte, 8'h00};
               phase_in = PhChkLo;
            end
            PhChkLo: begin
               check_in = {check_ff[15:8], rx_byte};
               left_in  = length_ff;
               // empty packet ends right on its check word
               if (length_ff == 16'd0) begin
                  phase_in  = PhHunt;
                  res_valid = 1'b1;
                  pend      = 1'b1;
               end else begin
                  phase_in = PhData;
               end
            end
            PhData: begin
               left_in   = left_ff - 16'd1;
               res_valid = 1'b1;
               pv        = 1'b1;
               if (left_in == 16'd0) begin
                  phase_in = PhHunt;
                  pend     = 1'b1;
               end
            end
            default: begin
               phase_in = (rx_byte == SyncFirst) ? PhGotFirst : PhHunt;
            end
         endcase
      end
   end

   // result fields, match fields filled in by the top level
   always_comb begin
      res                = '0;
      res.payload_valid  = pv;
      res.payload_byte   = pv ? rx_byte : 8'h00;
      res.packet_end     = pend;
      res.module_id      = module_in;
      res.command_id     = command_in;
      res.status_byte    = status_in;
      res.payload_length = length_in;
      res.check_word     = check_in;
   end

   assign held_module  = module_ff;
   assign held_command = command_ff;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhHunt;
         module_ff  <= 8'h00;
         command_ff <= 8'h00;
         status_ff  <= 8'h00;
         length_ff  <= 16'd0;
         check_ff   <= 16'd0;
         left_ff    <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         module_ff  <= module_in;
         command_ff <= command_in;
         status_ff  <= status_in;
         length_ff  <= length_in;
         check_ff   <= check_in;
         left_ff    <= left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/swpd_match.sv
// command table registers and first-match lookup on module and command
`default_nettype none

module swpd_match (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [swpd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [swpd_pkg::CsrDataWidth-1:0]   csr_wdata,
   input  wire logic [7:0]                          held_module,
   input  wire logic [7:0]                          held_command,
   output swpd_pkg::swpd_match_type                 match
);
   import swpd_pkg::*;

   logic [EntryIndexWidth-1:0] count_ff;
   logic [15:0]                entry_ff [TableEntries];
   logic [EntryIndexWidth-1:0] limit;

   // table writes, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < TableEntries; i++) begin
            entry_ff[i] <= 16'd0;
         end
      end else if (csr_we) begin
         if (csr_index == CsrEntryCount) begin
            count_ff <= csr_wdata[EntryIndexWidth-1:0];
         end
         for (int i = 0; i < TableEntries; i++) begin
            if (csr_index == CsrEntryZero + CsrIndexWidth'(i)) begin
               entry_ff[i] <= csr_wdata[15:0];
            end
         end
      end
   end

   // saturate the entry count at the table size
   assign limit = (count_ff > EntryIndexWidth'(TableEntries)) ?
                  EntryIndexWidth'(TableEntries) : count_ff;

   // parallel compare, lowest index wins
   always_comb begin
      match = '0;
      for (int i = TableEntries - 1; i >= 0; i--) begin
         if (EntryIndexWidth'(i) < limit &&
             entry_ff[i][15:8] == held_module &&
             entry_ff[i][7:0] == held_command) begin
            match.hit   = 1'b1;
            match.index = EntryIndexWidth'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/swpd_out_buf.sv
// two-deep result register with skid slot
`default_nettype none

module swpd_out_buf (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire swpd_pkg::swpd_result_type push_data,
   output logic                           can_take,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output swpd_pkg::swpd_result_type      out_data
);
   import swpd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   swpd_result_type main_ff, main_in;
   swpd_result_type skid_ff, skid_in;

   // refill the head from the skid slot first, else from the parser
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign can_take  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

>>> rtl/core/sync_word_packet_deframer.sv
// top level of the sync word packet deframer
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    rx_byte
//   rsp_chan  out        valid/ready    payload and header fields, table match
//   csr_*     in         write enable   entry_count, entry_zero..entry_five
//
// one byte per cycle while ready is high; the parser state machine and the
// six-way table compare finish in the accepting cycle; results are registered.
// reset is synchronous and needs no clearing pass; the table resets to zero.
// a stalled result sits in the output register while one more result is taken
// into the skid slot; req_chan.ready drops only once that slot is full.
`default_nettype none

module sync_word_packet_deframer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   swpd_req_if.sink                                 req_chan,
   swpd_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_we,
   input  wire logic [swpd_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [swpd_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import swpd_pkg::*;

   logic            can_take;
   logic            accept;
   logic            res_valid;
   swpd_result_type parse_res;
   swpd_result_type full_res;
   swpd_result_type out_data;
   swpd_match_type  match;
   logic [7:0]      held_module;
   logic [7:0]      held_command;

   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   swpd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_chan.rx_byte),
      .res_valid    (res_valid),
      .res          (parse_res),
      .held_module  (held_module),
      .held_command (held_command)
   );

   swpd_match u_match (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .held_module  (held_module),
      .held_command (held_command),
      .match        (match)
   );

   // table match is reported only on the packet's last transaction
   always_comb begin
      full_res             = parse_res;
      full_res.matched     = parse_res.packet_end && match.hit;
      full_res.entry_index = parse_res.packet_end ? match.index : '0;
   end

   swpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (full_res),
      .can_take  (can_take),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   // result fields onto the channel
   assign rsp_chan.payload_valid  = out_data.payload_valid;
   assign rsp_chan.payload_byte   = out_data.payload_byte;
   assign rsp_chan.packet_end     = out_data.packet_end;
   assign rsp_chan.module_id      = out_data.module_id;
   assign rsp_chan.command_id     = out_data.command_id;
   assign rsp_chan.status_byte    = out_data.status_byte;
   assign rsp_chan.payload_length = out_data.payload_length;
   assign rsp_chan.check_word     = out_data.check_word;
   assign rsp_chan.matched        = out_data.matched;
   assign rsp_chan.entry_index    = out_data.entry_index;

endmodule

`default_nettype wire
